FILE: hw/rtl/qnrm_pkg.sv
// shared types, constants and rounding helpers for the quaternion normaliser
// and rotation matrix builder; used by every module under hw/rtl but qnrm_chk
package qnrm_pkg;

	localparam int unsigned SQRT_STEPS = 25;
	localparam int unsigned DIV_STEPS  = 15;

	localparam logic [32:0]        QNORM_MIN_SQ  = 33'd68;
	localparam logic [14:0]        MIN_ACCEL_RST = 15'd512;
	localparam logic signed [17:0] DEG2RAD_K     = 18'sd73204;
	localparam logic signed [15:0] UNIT_ONE      = 16'sd16384;
	localparam logic [14:0]        UNIT_MAG      = 15'd16384;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_QSMALL  = 2'd2,
		ST_ASMALL  = 2'd3
	} status_t;

	// multiplier operations, each implies its operands and destination
	typedef enum logic [2:0] {
		MOP_NONE = 3'd0,
		MOP_QSQ  = 3'd1,
		MOP_ASQ  = 3'd2,
		MOP_M2   = 3'd3,
		MOP_ANG  = 3'd4,
		MOP_PRD  = 3'd5
	} mop_t;

	// iterative unit operations
	typedef enum logic [2:0] {
		IOP_NONE  = 3'd0,
		IOP_QSQRT = 3'd1,
		IOP_ASQRT = 3'd2,
		IOP_QDIV  = 3'd3,
		IOP_ADIV  = 3'd4
	} iop_t;

	typedef struct packed {
		logic       capture;
		mop_t       mul_op;
		logic [3:0] idx;
		logic       iter_start;
		iop_t       iop;
		logic       mat_wr;
		logic [1:0] row;
	} cmd_t;

	typedef struct packed {
		logic sample_valid;
		logic q_small;
		logic a_small;
		logic iter_done;
	} sts_t;

	typedef struct packed {
		logic        start;
		logic        is_div;
		logic [48:0] radicand;
		logic [24:0] divisor;
	} iter_req_t;

	typedef struct packed {
		logic        done;
		logic [24:0] result;
	} iter_rsp_t;

	typedef struct packed {
		logic signed [15:0] c0;
		logic signed [15:0] c1;
		logic signed [15:0] c2;
	} mrow_t;

	// Q2.28 -> Q1.14, half away from zero, clamped to +-1.0
	function automatic logic signed [15:0] rnd_sat14(input logic signed [33:0] v);
		logic [33:0] m;
		logic [19:0] r;
		m = v[33] ? 34'(-v) : 34'(v);
		r = 20'((m + 34'd8192) >> 14);
		if (r > 20'(UNIT_MAG))
			r = 20'(UNIT_MAG);
		rnd_sat14 = v[33] ? 16'(-{1'b0, r[14:0]}) : {1'b0, r[14:0]};
	endfunction

	// degrees times constant -> Q3.12 radians, half away from zero, saturated
	function automatic logic signed [15:0] ang_conv(input logic signed [35:0] p);
		logic [35:0] m;
		logic [19:0] r;
		logic [15:0] o;
		m = p[35] ? 36'(-p) : 36'(p);
		r = 20'((m + 36'd32768) >> 16);
		if (p[35]) begin
			if (r > 20'd32768)
				o = 16'h8000;
			else
				o = 16'(-{1'b0, r[15:0]});
		end else begin
			if (r > 20'd32767)
				o = 16'h7fff;
			else
				o = r[15:0];
		end
		ang_conv = o;
	endfunction

endpackage

FILE: hw/rtl/qnrm_iter.sv
// shared iterative unit: integer square root (two bits a step) and
// restoring division with clamped 15-bit quotient; uses qnrm_pkg
module qnrm_iter (
	input  logic                clk,
	input  logic                arst_n,
	input  qnrm_pkg::iter_req_t req,
	output qnrm_pkg::iter_rsp_t rsp
);

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic        div_q;
	logic        sat_q;
	logic [48:0] acc_q;
	logic [48:0] aux_q;
	logic [48:0] bit_q;
	logic [14:0] quot_q;

	logic [49:0] trial;
	logic [49:0] rhs;
	logic        ge;

	// trial subtrahend and the one compare shared by both modes
	always_comb begin
		trial = {1'b0, aux_q} + {1'b0, bit_q};
		rhs   = div_q ? {1'b0, aux_q} : trial;
		ge    = ({1'b0, acc_q} >= rhs);
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.is_div ? 5'(qnrm_pkg::DIV_STEPS - 1)
				                     : 5'(qnrm_pkg::SQRT_STEPS - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q - 5'd1;
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (req.start) begin
			div_q  <= req.is_div;
			acc_q  <= req.radicand;
			quot_q <= '0;
			if (req.is_div) begin
				aux_q <= 49'({req.divisor, 14'd0});
				sat_q <= ({1'b0, req.radicand} >= 50'({req.divisor, 15'd0}));
			end else begin
				aux_q <= '0;
				sat_q <= 1'b0;
			end
			bit_q <= 49'd1 << 48;
		end else if (busy_q) begin
			if (div_q) begin
				if (ge)
					acc_q <= acc_q - aux_q;
				quot_q <= {quot_q[13:0], ge};
				aux_q  <= aux_q >> 1;
			end else begin
				if (ge) begin
					acc_q <= acc_q - trial[48:0];
					aux_q <= (aux_q >> 1) + bit_q;
				end else begin
					aux_q <= aux_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
		end
	end

	// result word
	always_comb begin
		rsp.done = done_q;
		if (div_q) begin
			if (sat_q || quot_q > qnrm_pkg::UNIT_MAG)
				rsp.result = 25'(qnrm_pkg::UNIT_MAG);
			else
				rsp.result = 25'(quot_q);
		end else begin
			rsp.result = aux_q[24:0];
		end
	end

endmodule

FILE: hw/rtl/qnrm_dp.sv
// datapath: input capture, shared multiplier stage, sums, held state and
// matrix assembly; driven by qnrm_ctrl commands, uses qnrm_pkg
module qnrm_dp (
	input  logic                      clk,
	input  logic                      arst_n,
	input  qnrm_pkg::cmd_t            cmd,
	output qnrm_pkg::sts_t            sts,
	input  logic signed [15:0]        quat_w,
	input  logic signed [15:0]        quat_x,
	input  logic signed [15:0]        quat_y,
	input  logic signed [15:0]        quat_z,
	input  logic signed [15:0]        accel_x,
	input  logic signed [15:0]        accel_y,
	input  logic signed [15:0]        accel_z,
	input  logic signed [15:0]        roll_deg,
	input  logic signed [15:0]        pitch_deg,
	input  logic signed [15:0]        yaw_deg,
	input  logic                      sample_valid,
	input  logic                      cfg_valid,
	input  logic [14:0]               cfg_data,
	output qnrm_pkg::iter_req_t       iter_req,
	input  qnrm_pkg::iter_rsp_t       iter_rsp,
	output logic signed [15:0]        norm_w,
	output logic signed [15:0]        norm_x,
	output logic signed [15:0]        norm_y,
	output logic signed [15:0]        norm_z,
	output logic signed [15:0]        rot_col0,
	output logic signed [15:0]        rot_col1,
	output logic signed [15:0]        rot_col2,
	output logic signed [15:0]        unit_accel,
	output logic signed [15:0]        angle_rad
);

	// captured word
	logic signed [15:0] q_in_q [4];
	logic signed [15:0] a_in_q [3];
	logic signed [15:0] deg_q  [3];
	logic               sv_q;

	logic [14:0]        min_q;
	logic [32:0]        qsum_q;
	logic [32:0]        asum_q;
	logic [29:0]        m2_q;
	logic [24:0]        root_q;
	logic signed [30:0] pb_q [9];

	// held state
	logic signed [15:0]    hq_q   [4];
	qnrm_pkg::mrow_t       hm_q   [3];
	logic signed [15:0]    hua_q  [3];
	logic signed [15:0]    hang_q [3];

	// multiplier stage
	logic signed [17:0]    mul_a;
	logic signed [17:0]    mul_b;
	logic signed [35:0]    prod_s1;
	qnrm_pkg::mop_t        op_s1;
	logic [3:0]            idx_s1;

	logic signed [15:0]    div_x;
	logic [15:0]           div_m;
	logic signed [15:0]    div_res;
	logic                  div_wr;
	logic signed [33:0]    e [9];
	logic signed [33:0]    one28;

	// operand selection
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.mul_op)
			qnrm_pkg::MOP_QSQ: begin
				mul_a = 18'(q_in_q[cmd.idx[1:0]]);
				mul_b = 18'(q_in_q[cmd.idx[1:0]]);
			end
			qnrm_pkg::MOP_ASQ: begin
				mul_a = 18'(a_in_q[cmd.idx[1:0]]);
				mul_b = 18'(a_in_q[cmd.idx[1:0]]);
			end
			qnrm_pkg::MOP_M2: begin
				mul_a = $signed({3'b000, min_q});
				mul_b = $signed({3'b000, min_q});
			end
			qnrm_pkg::MOP_ANG: begin
				mul_a = 18'(deg_q[cmd.idx[1:0]]);
				mul_b = qnrm_pkg::DEG2RAD_K;
			end
			qnrm_pkg::MOP_PRD: begin
				unique case (cmd.idx)
					4'd0: begin mul_a = 18'(hq_q[2]); mul_b = 18'(hq_q[2]); end
					4'd1: begin mul_a = 18'(hq_q[3]); mul_b = 18'(hq_q[3]); end
					4'd2: begin mul_a = 18'(hq_q[1]); mul_b = 18'(hq_q[1]); end
					4'd3: begin mul_a = 18'(hq_q[1]); mul_b = 18'(hq_q[2]); end
					4'd4: begin mul_a = 18'(hq_q[0]); mul_b = 18'(hq_q[3]); end
					4'd5: begin mul_a = 18'(hq_q[1]); mul_b = 18'(hq_q[3]); end
					4'd6: begin mul_a = 18'(hq_q[0]); mul_b = 18'(hq_q[2]); end
					4'd7: begin mul_a = 18'(hq_q[2]); mul_b = 18'(hq_q[3]); end
					4'd8: begin mul_a = 18'(hq_q[0]); mul_b = 18'(hq_q[1]); end
					default: begin mul_a = '0; mul_b = '0; end
				endcase
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// product register and its destination tag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1  <= qnrm_pkg::MOP_NONE;
			idx_s1 <= '0;
		end else begin
			op_s1  <= cmd.mul_op;
			idx_s1 <= cmd.idx;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
	end

	// iterative unit request
	always_comb begin
		div_x = (cmd.iop == qnrm_pkg::IOP_ADIV) ? a_in_q[cmd.idx[1:0]] : q_in_q[cmd.idx[1:0]];
		div_m = div_x[15] ? 16'(-div_x) : div_x;
		iter_req.start   = cmd.iter_start;
		iter_req.is_div  = (cmd.iop == qnrm_pkg::IOP_QDIV) || (cmd.iop == qnrm_pkg::IOP_ADIV);
		iter_req.divisor = root_q;
		unique case (cmd.iop)
			qnrm_pkg::IOP_QSQRT: iter_req.radicand = {qsum_q, 16'd0};
			qnrm_pkg::IOP_ASQRT: iter_req.radicand = {asum_q, 16'd0};
			qnrm_pkg::IOP_QDIV,
			qnrm_pkg::IOP_ADIV:
				iter_req.radicand = 49'({div_m, 22'd0}) + 49'(root_q >> 1);
			default: iter_req.radicand = '0;
		endcase
		div_res = div_x[15] ? 16'(-{1'b0, iter_rsp.result[14:0]})
		                    : {1'b0, iter_rsp.result[14:0]};
		div_wr  = iter_rsp.done;
	end

	// matrix entries in Q2.28
	always_comb begin
		one28 = 34'sd1 << 28;
		e[0] = one28 - 34'sd2 * (34'(pb_q[0]) + 34'(pb_q[1]));
		e[1] = 34'sd2 * (34'(pb_q[3]) + 34'(pb_q[4]));
		e[2] = 34'sd2 * (34'(pb_q[5]) - 34'(pb_q[6]));
		e[3] = 34'sd2 * (34'(pb_q[3]) - 34'(pb_q[4]));
		e[4] = one28 - 34'sd2 * (34'(pb_q[2]) + 34'(pb_q[1]));
		e[5] = 34'sd2 * (34'(pb_q[7]) + 34'(pb_q[8]));
		e[6] = 34'sd2 * (34'(pb_q[5]) + 34'(pb_q[6]));
		e[7] = 34'sd2 * (34'(pb_q[7]) - 34'(pb_q[8]));
		e[8] = one28 - 34'sd2 * (34'(pb_q[2]) + 34'(pb_q[0]));
	end

	// capture, sums and scratch
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			q_in_q[0] <= quat_w;
			q_in_q[1] <= quat_x;
			q_in_q[2] <= quat_y;
			q_in_q[3] <= quat_z;
			a_in_q[0] <= accel_x;
			a_in_q[1] <= accel_y;
			a_in_q[2] <= accel_z;
			deg_q[0]  <= roll_deg;
			deg_q[1]  <= pitch_deg;
			deg_q[2]  <= yaw_deg;
			sv_q      <= sample_valid;
			qsum_q    <= '0;
			asum_q    <= '0;
		end else begin
			if (op_s1 == qnrm_pkg::MOP_QSQ)
				qsum_q <= qsum_q + {2'b00, prod_s1[30:0]};
			if (op_s1 == qnrm_pkg::MOP_ASQ)
				asum_q <= asum_q + {2'b00, prod_s1[30:0]};
		end
		if (op_s1 == qnrm_pkg::MOP_M2)
			m2_q <= prod_s1[29:0];
		if (op_s1 == qnrm_pkg::MOP_PRD)
			pb_q[idx_s1] <= prod_s1[30:0];
		if (iter_rsp.done && (cmd.iop == qnrm_pkg::IOP_QSQRT || cmd.iop == qnrm_pkg::IOP_ASQRT))
			root_q <= iter_rsp.result;
	end

	// configuration and held state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q   <= qnrm_pkg::MIN_ACCEL_RST;
			hq_q[0] <= qnrm_pkg::UNIT_ONE;
			hq_q[1] <= '0;
			hq_q[2] <= '0;
			hq_q[3] <= '0;
			hm_q[0] <= '{c0: qnrm_pkg::UNIT_ONE, c1: '0, c2: '0};
			hm_q[1] <= '{c0: '0, c1: qnrm_pkg::UNIT_ONE, c2: '0};
			hm_q[2] <= '{c0: '0, c1: '0, c2: qnrm_pkg::UNIT_ONE};
			for (int i = 0; i < 3; i++) begin
				hua_q[i]  <= '0;
				hang_q[i] <= '0;
			end
		end else begin
			if (cfg_valid)
				min_q <= cfg_data;
			if (op_s1 == qnrm_pkg::MOP_ANG)
				hang_q[idx_s1[1:0]] <= qnrm_pkg::ang_conv(prod_s1);
			if (div_wr && cmd.iop == qnrm_pkg::IOP_QDIV)
				hq_q[cmd.idx[1:0]] <= div_res;
			if (div_wr && cmd.iop == qnrm_pkg::IOP_ADIV)
				hua_q[cmd.idx[1:0]] <= div_res;
			if (cmd.mat_wr) begin
				hm_q[0] <= '{c0: qnrm_pkg::rnd_sat14(e[0]), c1: qnrm_pkg::rnd_sat14(e[1]),
				             c2: qnrm_pkg::rnd_sat14(e[2])};
				hm_q[1] <= '{c0: qnrm_pkg::rnd_sat14(e[3]), c1: qnrm_pkg::rnd_sat14(e[4]),
				             c2: qnrm_pkg::rnd_sat14(e[5])};
				hm_q[2] <= '{c0: qnrm_pkg::rnd_sat14(e[6]), c1: qnrm_pkg::rnd_sat14(e[7]),
				             c2: qnrm_pkg::rnd_sat14(e[8])};
			end
		end
	end

	// status back to the controller
	always_comb begin
		sts.sample_valid = sv_q;
		sts.q_small      = (qsum_q < qnrm_pkg::QNORM_MIN_SQ);
		sts.a_small      = (asum_q < {3'b000, m2_q}) || (asum_q == '0);
		sts.iter_done    = iter_rsp.done;
	end

	// result word from held state
	always_comb begin
		norm_w     = hq_q[0];
		norm_x     = hq_q[1];
		norm_y     = hq_q[2];
		norm_z     = hq_q[3];
		rot_col0   = hm_q[cmd.row].c0;
		rot_col1   = hm_q[cmd.row].c1;
		rot_col2   = hm_q[cmd.row].c2;
		unit_accel = hua_q[cmd.row];
		angle_rad  = hang_q[cmd.row];
	end

endmodule

FILE: hw/rtl/qnrm_ctrl.sv
// controller: one-hot sequencer that steps the datapath through the
// normalisation, angle, accel and matrix phases; uses qnrm_pkg
module qnrm_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [1:0]     status,
	output logic           last_row,
	input  qnrm_pkg::sts_t sts,
	output qnrm_pkg::cmd_t cmd
);

	typedef enum logic [18:0] {
		S_IDLE   = 19'b0000000000000000001,
		S_QSQ    = 19'b0000000000000000010,
		S_QWAIT  = 19'b0000000000000000100,
		S_QCHK   = 19'b0000000000000001000,
		S_QROOT  = 19'b0000000000000010000,
		S_QDIV   = 19'b0000000000000100000,
		S_QDWAIT = 19'b0000000000001000000,
		S_ANG    = 19'b0000000000010000000,
		S_M2     = 19'b0000000000100000000,
		S_ASQ    = 19'b0000000001000000000,
		S_AWAIT  = 19'b0000000010000000000,
		S_ACHK   = 19'b0000000100000000000,
		S_AROOT  = 19'b0000001000000000000,
		S_ADIV   = 19'b0000010000000000000,
		S_ADWAIT = 19'b0000100000000000000,
		S_PRD    = 19'b0001000000000000000,
		S_PWAIT  = 19'b0010000000000000000,
		S_MAT    = 19'b0100000000000000000,
		S_OUT    = 19'b1000000000000000000
	} state_t;

	state_t              state_q, state_d;
	logic [3:0]          idx_q, idx_d;
	logic [1:0]          row_q, row_d;
	qnrm_pkg::status_t   status_q, status_d;

	// next state and commands
	always_comb begin
		state_d  = state_q;
		idx_d    = idx_q;
		row_d    = row_q;
		status_d = status_q;
		cmd      = '0;
		cmd.idx  = idx_q;
		cmd.row  = row_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					idx_d       = '0;
					state_d     = S_QSQ;
				end
			end
			S_QSQ: begin
				cmd.mul_op = qnrm_pkg::MOP_QSQ;
				if (idx_q == 4'd3) begin
					idx_d   = '0;
					state_d = S_QWAIT;
				end else begin
					idx_d = idx_q + 4'd1;
				end
			end
			S_QWAIT: state_d = S_QCHK;
			S_QCHK: begin
				priority if (!sts.sample_valid) begin
					status_d = qnrm_pkg::ST_INVALID;
					row_d    = '0;
					state_d  = S_OUT;
				end else if (sts.q_small) begin
					status_d = qnrm_pkg::ST_QSMALL;
					row_d    = '0;
					state_d  = S_OUT;
				end else begin
					cmd.iter_start = 1'b1;
					cmd.iop        = qnrm_pkg::IOP_QSQRT;
					state_d        = S_QROOT;
				end
			end
			S_QROOT: begin
				cmd.iop = qnrm_pkg::IOP_QSQRT;
				if (sts.iter_done) begin
					idx_d   = '0;
					state_d = S_QDIV;
				end
			end
			S_QDIV: begin
				cmd.iter_start = 1'b1;
				cmd.iop        = qnrm_pkg::IOP_QDIV;
				state_d        = S_QDWAIT;
			end
			S_QDWAIT: begin
				cmd.iop = qnrm_pkg::IOP_QDIV;
				if (sts.iter_done) begin
					if (idx_q == 4'd3) begin
						idx_d   = '0;
						state_d = S_ANG;
					end else begin
						idx_d   = idx_q + 4'd1;
						state_d = S_QDIV;
					end
				end
			end
			S_ANG: begin
				cmd.mul_op = qnrm_pkg::MOP_ANG;
				if (idx_q == 4'd2) begin
					idx_d   = '0;
					state_d = S_M2;
				end else begin
					idx_d = idx_q + 4'd1;
				end
			end
			S_M2: begin
				cmd.mul_op = qnrm_pkg::MOP_M2;
				state_d    = S_ASQ;
			end
			S_ASQ: begin
				cmd.mul_op = qnrm_pkg::MOP_ASQ;
				if (idx_q == 4'd2) begin
					idx_d   = '0;
					state_d = S_AWAIT;
				end else begin
					idx_d = idx_q + 4'd1;
				end
			end
			S_AWAIT: state_d = S_ACHK;
			S_ACHK: begin
				if (sts.a_small) begin
					status_d = qnrm_pkg::ST_ASMALL;
					row_d    = '0;
					state_d  = S_OUT;
				end else begin
					cmd.iter_start = 1'b1;
					cmd.iop        = qnrm_pkg::IOP_ASQRT;
					state_d        = S_AROOT;
				end
			end
			S_AROOT: begin
				cmd.iop = qnrm_pkg::IOP_ASQRT;
				if (sts.iter_done) begin
					idx_d   = '0;
					state_d = S_ADIV;
				end
			end
			S_ADIV: begin
				cmd.iter_start = 1'b1;
				cmd.iop        = qnrm_pkg::IOP_ADIV;
				state_d        = S_ADWAIT;
			end
			S_ADWAIT: begin
				cmd.iop = qnrm_pkg::IOP_ADIV;
				if (sts.iter_done) begin
					if (idx_q == 4'd2) begin
						idx_d   = '0;
						state_d = S_PRD;
					end else begin
						idx_d   = idx_q + 4'd1;
						state_d = S_ADIV;
					end
				end
			end
			S_PRD: begin
				cmd.mul_op = qnrm_pkg::MOP_PRD;
				if (idx_q == 4'd8) begin
					idx_d   = '0;
					state_d = S_PWAIT;
				end else begin
					idx_d = idx_q + 4'd1;
				end
			end
			S_PWAIT: state_d = S_MAT;
			S_MAT: begin
				cmd.mat_wr = 1'b1;
				status_d   = qnrm_pkg::ST_OK;
				row_d      = '0;
				state_d    = S_OUT;
			end
			S_OUT: begin
				if (out_ready) begin
					if (row_q == 2'd2)
						state_d = S_IDLE;
					else
						row_d = row_q + 2'd1;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			idx_q    <= '0;
			row_q    <= '0;
			status_q <= qnrm_pkg::ST_OK;
		end else begin
			state_q  <= state_d;
			idx_q    <= idx_d;
			row_q    <= row_d;
			status_q <= status_d;
		end
	end

	// handshake and word control
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign status    = status_q;
	assign last_row  = (row_q == 2'd2);

endmodule

FILE: hw/rtl/quat_normalize_rotation_matrix.sv
// top level: quaternion normaliser, degree to radian conversion, accel
// normaliser and rotation matrix builder; instantiates qnrm_ctrl, qnrm_dp, qnrm_iter
//
// One input word yields three result words, one per matrix row and axis
// (row 0, 1, 2, last_row on row 2), all showing the held state after the
// sample has been taken in. The block works on one sample at a time: in_ready
// is high only while idle. Most of the time from acceptance to the first
// result word goes to the shared iterative unit, which does two 25-step
// square roots and seven 15-step divisions in turn; the rest goes mostly to
// multiplier issues for the sums of squares, angles and the nine quaternion
// products. Invalid samples and small quaternion norms reach the result
// words before any square root, small accel norms after the quaternion
// normalisation and angle steps. min_accel_norm is written through
// cfg_valid/cfg_data, always ready, and must only change while the block is idle.
module quat_normalize_rotation_matrix (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] quat_w,
	input  logic signed [15:0] quat_x,
	input  logic signed [15:0] quat_y,
	input  logic signed [15:0] quat_z,
	input  logic signed [15:0] accel_x,
	input  logic signed [15:0] accel_y,
	input  logic signed [15:0] accel_z,
	input  logic signed [15:0] roll_deg,
	input  logic signed [15:0] pitch_deg,
	input  logic signed [15:0] yaw_deg,
	input  logic               sample_valid,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic [1:0]         row,
	output logic               last_row,
	output logic signed [15:0] norm_w,
	output logic signed [15:0] norm_x,
	output logic signed [15:0] norm_y,
	output logic signed [15:0] norm_z,
	output logic signed [15:0] rot_col0,
	output logic signed [15:0] rot_col1,
	output logic signed [15:0] rot_col2,
	output logic signed [15:0] unit_accel,
	output logic signed [15:0] angle_rad,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [14:0]        cfg_data
);

	qnrm_pkg::cmd_t      cmd;
	qnrm_pkg::sts_t      sts;
	qnrm_pkg::iter_req_t iter_req;
	qnrm_pkg::iter_rsp_t iter_rsp;

	// register writes always land at once
	assign cfg_ready = 1'b1;
	assign row       = cmd.row;

	qnrm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.last_row  (last_row),
		.sts       (sts),
		.cmd       (cmd)
	);

	qnrm_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.quat_w       (quat_w),
		.quat_x       (quat_x),
		.quat_y       (quat_y),
		.quat_z       (quat_z),
		.accel_x      (accel_x),
		.accel_y      (accel_y),
		.accel_z      (accel_z),
		.roll_deg     (roll_deg),
		.pitch_deg    (pitch_deg),
		.yaw_deg      (yaw_deg),
		.sample_valid (sample_valid),
		.cfg_valid    (cfg_valid),
		.cfg_data     (cfg_data),
		.iter_req     (iter_req),
		.iter_rsp     (iter_rsp),
		.norm_w       (norm_w),
		.norm_x       (norm_x),
		.norm_y       (norm_y),
		.norm_z       (norm_z),
		.rot_col0     (rot_col0),
		.rot_col1     (rot_col1),
		.rot_col2     (rot_col2),
		.unit_accel   (unit_accel),
		.angle_rad    (angle_rad)
	);

	qnrm_iter u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (iter_req),
		.rsp    (iter_rsp)
	);

endmodule

FILE: hw/rtl/qnrm_chk.sv
// port-level checker for quat_normalize_rotation_matrix and its bind;
// sees the top-level ports only
module qnrm_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [1:0]         status,
	input logic [1:0]         row,
	input logic               last_row,
	input logic signed [15:0] rot_col0
);

	// one sample at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while a sample is in work");

	// no input taken while results are shown
	a_out_excl_in: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("ready during result delivery");

	// rows advance in order
	a_row_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_row |=> out_valid && row == $past(row) + 2'd1)
		else $error("row sequence broken");

	// three words then idle
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last_row |=> !out_valid)
		else $error("extra word after last row");

	// stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(row) && $stable(status)
			&& $stable(rot_col0))
		else $error("stalled word changed");

endmodule

bind quat_normalize_rotation_matrix qnrm_chk u_qnrm_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.status    (status),
	.row       (row),
	.last_row  (last_row),
	.rot_col0  (rot_col0)
);
